@@ rtl/csoc_pkg.sv @@
// ----------------------------------------------------------------------------
// csoc_pkg
// Shared field widths and the per-transaction tag for the current-sense
// offset calibration and averaging pipeline.
// ----------------------------------------------------------------------------
package csoc_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SCALE_W     = 32;
    localparam int RESULT_W    = 32;
    localparam int FRAC_W      = 16;
    localparam int DIV_CHUNK_W = 16;

    // Control flags that travel with one transaction down the pipeline.
    typedef struct packed {
        logic active;
        logic calibrated;
        logic avg_done;
        logic inst_neg;
        logic avg_neg;
    } csoc_tag_t;

endpackage

@@ rtl/csoc_front.sv @@
// ----------------------------------------------------------------------------
// csoc_front
// Calibration and block accumulation state. Updates once per accepted
// transaction and registers the offset-corrected difference and block sum.
// ----------------------------------------------------------------------------
module csoc_front #(
    parameter int ADC_BITS    = 12,
    parameter int CAL_SAMPLES = 101,
    parameter int AVG_SAMPLES = 101,
    localparam int AVG_CNT_W  = $clog2(AVG_SAMPLES + 1),
    localparam int AVG_SUM_W  = ADC_BITS + AVG_CNT_W + 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [csoc_pkg::SAMPLE_W-1:0]       sample,
    output csoc_pkg::csoc_tag_t                 tag,
    output logic signed [ADC_BITS:0]            diff,
    output logic signed [AVG_SUM_W-1:0]         block_sum
);

    localparam int CAL_CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int CAL_SUM_W = ADC_BITS + CAL_CNT_W;
    localparam int ZO_K      = CAL_SUM_W + CAL_CNT_W;
    localparam int ZO_MW     = CAL_SUM_W + 2;
    localparam int ZO_PW     = CAL_SUM_W + ZO_MW;
    localparam longint ZO_MAGIC = ((longint'(1) << ZO_K) + CAL_SAMPLES - 1) / CAL_SAMPLES;

    logic [CAL_CNT_W-1:0]         cal_count_reg, cal_count_next;
    logic [CAL_SUM_W-1:0]         cal_sum_reg, cal_sum_next;
    logic [ADC_BITS-1:0]          zero_offset_reg, zero_offset_next;
    logic                         is_cal_reg, is_cal_next;
    logic [AVG_CNT_W-1:0]         avg_count_reg, avg_count_next;
    logic signed [AVG_SUM_W-1:0]  avg_sum_reg, avg_sum_next;

    csoc_pkg::csoc_tag_t          tag_reg, tag_next;
    logic signed [ADC_BITS:0]     diff_reg;
    logic signed [AVG_SUM_W-1:0]  block_sum_reg;

    logic [ADC_BITS-1:0]          s;
    logic [CAL_CNT_W-1:0]         cal_count_inc;
    logic [CAL_SUM_W-1:0]         cal_sum_inc;
    logic [ZO_PW-1:0]             zo_prod;
    logic signed [ADC_BITS:0]     d;
    logic signed [AVG_SUM_W-1:0]  acc;
    logic [AVG_CNT_W-1:0]         avg_count_inc;
    logic                         cal_done;
    logic                         blk_done;

    assign s             = ADC_BITS'(sample);
    assign cal_count_inc = cal_count_reg + CAL_CNT_W'(1);
    assign cal_sum_inc   = cal_sum_reg + CAL_SUM_W'(s);
    // The mean of the calibration samples uses a reciprocal multiply that is
    // exact over the whole range of the sum.
    assign zo_prod       = ZO_PW'(cal_sum_inc) * ZO_PW'(ZO_MAGIC);
    assign cal_done      = !is_cal_reg && (s != '0)
                           && (cal_count_inc >= CAL_CNT_W'(CAL_SAMPLES));
    assign d             = $signed({1'b0, s}) - $signed({1'b0, zero_offset_reg});
    assign acc           = avg_sum_reg + AVG_SUM_W'(d);
    assign avg_count_inc = avg_count_reg + AVG_CNT_W'(1);
    assign blk_done      = avg_count_inc >= AVG_CNT_W'(AVG_SAMPLES);

    always_comb
    begin
        cal_count_next   = cal_count_reg;
        cal_sum_next     = cal_sum_reg;
        zero_offset_next = zero_offset_reg;
        is_cal_next      = is_cal_reg;
        avg_count_next   = avg_count_reg;
        avg_sum_next     = avg_sum_reg;
        if (!is_cal_reg)
        begin
            // Zero samples are skipped while the offset is being measured.
            if (s != '0)
            begin
                cal_count_next = cal_count_inc;
                cal_sum_next   = cal_sum_inc;
                if (cal_done)
                begin
                    zero_offset_next = zo_prod[ZO_K +: ADC_BITS];
                    is_cal_next      = 1'b1;
                end
            end
        end
        else if (blk_done)
        begin
            avg_count_next = '0;
            avg_sum_next   = '0;
        end
        else
        begin
            avg_count_next = avg_count_inc;
            avg_sum_next   = acc;
        end
    end

    always_comb
    begin
        tag_next.active     = is_cal_reg;
        tag_next.calibrated = is_cal_reg || cal_done;
        tag_next.avg_done   = is_cal_reg && blk_done;
        tag_next.inst_neg   = d[ADC_BITS];
        tag_next.avg_neg    = acc[AVG_SUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_count_reg   <= '0;
            cal_sum_reg     <= '0;
            zero_offset_reg <= '0;
            is_cal_reg      <= 1'b0;
            avg_count_reg   <= '0;
            avg_sum_reg     <= '0;
        end
        else if (accept)
        begin
            cal_count_reg   <= cal_count_next;
            cal_sum_reg     <= cal_sum_next;
            zero_offset_reg <= zero_offset_next;
            is_cal_reg      <= is_cal_next;
            avg_count_reg   <= avg_count_next;
            avg_sum_reg     <= avg_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_reg       <= tag_next;
            diff_reg      <= d;
            block_sum_reg <= acc;
        end
    end

    assign tag       = tag_reg;
    assign diff      = diff_reg;
    assign block_sum = block_sum_reg;

`ifndef NO_ASSERTIONS
    a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        is_cal_reg |=> is_cal_reg)
        else $error("calibration flag dropped after it was set");
`endif

endmodule

@@ rtl/csoc_mult.sv @@
// ----------------------------------------------------------------------------
// csoc_mult
// Scaling stage: takes magnitudes of the difference and of the block sum
// and multiplies both by the Q16.16 scale, dropping the fraction bits.
// ----------------------------------------------------------------------------
module csoc_mult #(
    parameter int ADC_BITS    = 12,
    parameter int AVG_SAMPLES = 101,
    localparam int AVG_CNT_W  = $clog2(AVG_SAMPLES + 1),
    localparam int AVG_SUM_W  = ADC_BITS + AVG_CNT_W + 1,
    localparam int MAG_W      = AVG_SUM_W - 1,
    localparam int INST_W     = ADC_BITS + csoc_pkg::SCALE_W - csoc_pkg::FRAC_W,
    localparam int Y_W        = MAG_W + csoc_pkg::SCALE_W - csoc_pkg::FRAC_W
) (
    input  logic                              clk,
    input  logic                              load,
    input  csoc_pkg::csoc_tag_t               tag_in,
    input  logic signed [ADC_BITS:0]          diff,
    input  logic signed [AVG_SUM_W-1:0]       block_sum,
    input  logic [csoc_pkg::SCALE_W-1:0]      scale,
    output csoc_pkg::csoc_tag_t               tag,
    output logic [INST_W-1:0]                 inst_mag,
    output logic [Y_W-1:0]                    avg_y
);

    localparam int IP_W = ADC_BITS + csoc_pkg::SCALE_W;
    localparam int AP_W = MAG_W + csoc_pkg::SCALE_W;

    csoc_pkg::csoc_tag_t          tag_reg;
    logic [INST_W-1:0]            inst_mag_reg;
    logic [Y_W-1:0]               avg_y_reg;

    logic signed [ADC_BITS:0]     diff_abs;
    logic signed [AVG_SUM_W-1:0]  sum_abs;
    logic [ADC_BITS-1:0]          d_mag;
    logic [MAG_W-1:0]             s_mag;
    logic [IP_W-1:0]              inst_prod;
    logic [AP_W-1:0]              avg_prod;

    always_comb
    begin
        diff_abs = diff[ADC_BITS] ? -diff : diff;
        sum_abs  = block_sum[AVG_SUM_W-1] ? -block_sum : block_sum;
        // A step that reports no value carries a zero magnitude, which the
        // output stage turns into zero whatever the sign.
        d_mag    = tag_in.active ? diff_abs[ADC_BITS-1:0] : '0;
        s_mag    = tag_in.avg_done ? sum_abs[MAG_W-1:0] : '0;
    end

    assign inst_prod = IP_W'(d_mag) * IP_W'(scale);
    assign avg_prod  = AP_W'(s_mag) * AP_W'(scale);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tag_reg      <= tag_in;
            inst_mag_reg <= inst_prod[csoc_pkg::FRAC_W +: INST_W];
            avg_y_reg    <= avg_prod[csoc_pkg::FRAC_W +: Y_W];
        end
    end

    assign tag      = tag_reg;
    assign inst_mag = inst_mag_reg;
    assign avg_y    = avg_y_reg;

endmodule

@@ rtl/csoc_div_step.sv @@
// ----------------------------------------------------------------------------
// csoc_div_step
// One stage of the pipelined division by AVG_SAMPLES: divides the running
// remainder joined with the next chunk of the dividend by a reciprocal
// multiply and appends the partial quotient.
// ----------------------------------------------------------------------------
module csoc_div_step #(
    parameter int AVG_SAMPLES = 101,
    parameter int INST_W      = 28,
    parameter int YP_W        = 48,
    parameter int STEP        = 0,
    localparam int REM_W      = $clog2(AVG_SAMPLES + 1)
) (
    input  logic                  clk,
    input  logic                  load,
    input  csoc_pkg::csoc_tag_t   tag_in,
    input  logic [INST_W-1:0]     inst_in,
    input  logic [YP_W-1:0]       y_in,
    input  logic [REM_W-1:0]      rem_in,
    input  logic [YP_W-1:0]       quo_in,
    output csoc_pkg::csoc_tag_t   tag,
    output logic [INST_W-1:0]     inst,
    output logic [YP_W-1:0]       y,
    output logic [REM_W-1:0]      rem,
    output logic [YP_W-1:0]       quo
);

    localparam int C     = csoc_pkg::DIV_CHUNK_W;
    localparam int V_W   = REM_W + C;
    localparam int K     = V_W + REM_W;
    localparam int M_W   = V_W + 2;
    localparam int P_W   = V_W + M_W;
    localparam int MSB   = YP_W - 1 - STEP * C;
    localparam longint MAGIC = ((longint'(1) << K) + AVG_SAMPLES - 1) / AVG_SAMPLES;

    csoc_pkg::csoc_tag_t  tag_reg;
    logic [INST_W-1:0]    inst_reg;
    logic [YP_W-1:0]      y_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [YP_W-1:0]      quo_reg;

    logic [V_W-1:0]       v;
    logic [P_W-1:0]       prod;
    logic [C-1:0]         qd;
    logic [V_W-1:0]       r;

    // The remainder is below AVG_SAMPLES, so the partial quotient fits a chunk.
    assign v    = {rem_in, y_in[MSB -: C]};
    assign prod = P_W'(v) * P_W'(MAGIC);
    assign qd   = prod[K +: C];
    assign r    = v - V_W'(qd) * V_W'(AVG_SAMPLES);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tag_reg  <= tag_in;
            inst_reg <= inst_in;
            y_reg    <= y_in;
            rem_reg  <= r[REM_W-1:0];
            quo_reg  <= (quo_in << C) | YP_W'(qd);
        end
    end

    assign tag  = tag_reg;
    assign inst = inst_reg;
    assign y    = y_reg;
    assign rem  = rem_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/current_sense_offset_cal_average.sv @@
// ----------------------------------------------------------------------------
// current_sense_offset_cal_average
// Takes one current-sense ADC sample per transaction and returns one result
// per transaction. After reset the block measures its zero offset: zero
// samples are skipped and the mean of the first CAL_SAMPLES nonzero samples
// becomes the offset; until then instant_current and average_valid are 0.
// Afterwards each result carries the negated current of its sample in
// microamps (current_scale is microamps per count, unsigned Q16.16) and,
// every AVG_SAMPLES samples, the negated block mean with average_valid set.
// Values truncate toward zero and saturate to 32-bit signed. A sample can
// be taken every cycle unless sample_stall is high; it passes the front and
// scaling stages, the division of the scaled block sum by AVG_SAMPLES in
// 16-bit chunks and the output register. The pipeline keeps accepting
// samples while a result waits, until every stage holds one. The user must
// write current_scale only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module current_sense_offset_cal_average #(
    parameter int ADC_BITS    = 12,
    parameter int CAL_SAMPLES = 101,
    parameter int AVG_SAMPLES = 101
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [csoc_pkg::SCALE_W-1:0]           cfg_wdata,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic [csoc_pkg::SAMPLE_W-1:0]          sample,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [csoc_pkg::RESULT_W-1:0]   instant_current,
    output logic signed [csoc_pkg::RESULT_W-1:0]   average_current,
    output logic                                   average_valid,
    output logic                                   calibrated
);

    localparam int AVG_CNT_W = $clog2(AVG_SAMPLES + 1);
    localparam int AVG_SUM_W = ADC_BITS + AVG_CNT_W + 1;
    localparam int MAG_W     = AVG_SUM_W - 1;
    localparam int INST_W    = ADC_BITS + csoc_pkg::SCALE_W - csoc_pkg::FRAC_W;
    localparam int Y_W       = MAG_W + csoc_pkg::SCALE_W - csoc_pkg::FRAC_W;
    localparam int NCH       = (Y_W + csoc_pkg::DIV_CHUNK_W - 1) / csoc_pkg::DIV_CHUNK_W;
    localparam int YP_W      = NCH * csoc_pkg::DIV_CHUNK_W;
    localparam int NSTG      = NCH + 3;

    function automatic logic [csoc_pkg::RESULT_W-1:0] neg_sat(
        input logic        neg,
        input logic [63:0] mag
    );
        logic [csoc_pkg::RESULT_W-1:0] res;
        if (neg)
            res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        else
            res = (mag >= 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        return res;
    endfunction

    logic [csoc_pkg::SCALE_W-1:0]   current_scale_reg;

    logic [NSTG-1:0]                valid_reg, valid_next;
    logic [NSTG:0]                  ready;
    logic [NSTG-1:0]                vin;
    logic [NSTG-1:0]                load;

    csoc_pkg::csoc_tag_t            front_tag;
    logic signed [ADC_BITS:0]       front_diff;
    logic signed [AVG_SUM_W-1:0]    front_sum;
    logic [Y_W-1:0]                 avg_y;

    csoc_pkg::csoc_tag_t            tag_d  [0:NCH];
    logic [INST_W-1:0]              inst_d [0:NCH];
    logic [YP_W-1:0]                y_d    [0:NCH];
    logic [AVG_CNT_W-1:0]           rem_d  [0:NCH];
    logic [YP_W-1:0]                quo_d  [0:NCH];

    logic [csoc_pkg::RESULT_W-1:0]  instant_current_reg;
    logic [csoc_pkg::RESULT_W-1:0]  average_current_reg;
    logic                           average_valid_reg;
    logic                           calibrated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            current_scale_reg <= '0;
        else if (cfg_we)
            current_scale_reg <= cfg_wdata;
    end

    // A stage takes new data when it is empty or its successor moves on.
    always_comb
    begin
        ready[NSTG] = !result_stall;
        for (int i = NSTG - 1; i >= 0; i--)
            ready[i] = !valid_reg[i] || ready[i+1];
    end

    assign vin        = {valid_reg[NSTG-2:0], sample_valid};
    assign load       = ready[NSTG-1:0] & vin;
    assign valid_next = load | (~ready[NSTG-1:0] & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign sample_stall = !ready[0];
    assign result_valid = valid_reg[NSTG-1];

    csoc_front #(
        .ADC_BITS    (ADC_BITS),
        .CAL_SAMPLES (CAL_SAMPLES),
        .AVG_SAMPLES (AVG_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (load[0]),
        .sample    (sample),
        .tag       (front_tag),
        .diff      (front_diff),
        .block_sum (front_sum)
    );

    csoc_mult #(
        .ADC_BITS    (ADC_BITS),
        .AVG_SAMPLES (AVG_SAMPLES)
    ) u_mult (
        .clk       (clk),
        .load      (load[1]),
        .tag_in    (front_tag),
        .diff      (front_diff),
        .block_sum (front_sum),
        .scale     (current_scale_reg),
        .tag       (tag_d[0]),
        .inst_mag  (inst_d[0]),
        .avg_y     (avg_y)
    );

    assign y_d[0]   = YP_W'(avg_y);
    assign rem_d[0] = '0;
    assign quo_d[0] = '0;

    for (genvar j = 0; j < NCH; j++)
    begin : g_div
        csoc_div_step #(
            .AVG_SAMPLES (AVG_SAMPLES),
            .INST_W      (INST_W),
            .YP_W        (YP_W),
            .STEP        (j)
        ) u_div (
            .clk     (clk),
            .load    (load[j+2]),
            .tag_in  (tag_d[j]),
            .inst_in (inst_d[j]),
            .y_in    (y_d[j]),
            .rem_in  (rem_d[j]),
            .quo_in  (quo_d[j]),
            .tag     (tag_d[j+1]),
            .inst    (inst_d[j+1]),
            .y       (y_d[j+1]),
            .rem     (rem_d[j+1]),
            .quo     (quo_d[j+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (load[NSTG-1])
        begin
            instant_current_reg <= neg_sat(tag_d[NCH].inst_neg, 64'(inst_d[NCH]));
            average_current_reg <= neg_sat(tag_d[NCH].avg_neg, 64'(quo_d[NCH]));
            average_valid_reg   <= tag_d[NCH].avg_done;
            calibrated_reg      <= tag_d[NCH].calibrated;
        end
    end

    assign instant_current = instant_current_reg;
    assign average_current = average_current_reg;
    assign average_valid   = average_valid_reg;
    assign calibrated      = calibrated_reg;

`ifndef NO_ASSERTIONS
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (&valid_reg))
        else $error("input stalled while a pipeline stage is empty");

    a_avg_needs_cal: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && average_valid) |-> calibrated)
        else $error("block average reported before calibration");

    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !average_valid) |-> (average_current == '0))
        else $error("average_current nonzero without average_valid");

    a_uncal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !calibrated) |-> (instant_current == '0 && !average_valid))
        else $error("current reported while uncalibrated");
`endif

endmodule
